### design/gmcf_pkg.sv
// ----------------------------------------------------------------------------
// gmcf_pkg
// Shared widths, codes and the command word passed from the front end to the
// back end of the group minimum-count filter.
// ----------------------------------------------------------------------------
package gmcf_pkg;

  localparam int KEY_W   = 32;
  localparam int PAY_W   = 64;
  localparam int MIN_W   = 6;
  localparam int COUNT_W = 7;
  localparam int FILL_W  = 6;

  // the hold buffer never keeps more than this many records of one run
  localparam int HOLD_LIMIT = 63;

  localparam logic [MIN_W-1:0]   MIN_COUNT_RST = 6'd50;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = 7'd127;

  // command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // input action codes
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_EOS    = 1'b1;

  // output kind codes
  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_RUN_END = 1'b1;

  // one command for the back end
  typedef struct packed {
    logic              end_flag;  // send end marker for end_key first
    logic [KEY_W-1:0]  end_key;
    logic [FILL_W-1:0] rel_n;     // held records to release
    logic              rec;       // send the record itself after the release
    logic              hold;      // store payload in the hold buffer
    logic [FILL_W-1:0] idx;       // hold buffer slot for the store
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
  } cmd_t;

endpackage

### design/gmcf_fifo.sv
// ----------------------------------------------------------------------------
// gmcf_fifo
// Small command queue that decouples the classifying front end from the
// output sequencer.
// ----------------------------------------------------------------------------
module gmcf_fifo
  import gmcf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t pop_data,
  output logic full,
  output logic empty
);

  cmd_t                 slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_W:0]     cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full     = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/gmcf_front.sv
// ----------------------------------------------------------------------------
// gmcf_front
// Accepts input words, tracks the current run of equal keys and turns words
// into commands for the back end: hold, release, pass, end marker.
// ----------------------------------------------------------------------------
module gmcf_front
  import gmcf_pkg::*;
#(
  parameter int HOLD_DEPTH = 64
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_action,
  input  logic [KEY_W-1:0] in_user_key,
  input  logic [PAY_W-1:0] in_payload,
  input  logic             cfg_we,
  input  logic [MIN_W-1:0] cfg_wdata,
  output logic             q_push,
  output cmd_t             q_data,
  input  logic             q_full
);

  localparam int HOLD_CAP = (HOLD_DEPTH < HOLD_LIMIT) ? HOLD_DEPTH : HOLD_LIMIT;
  localparam logic [FILL_W-1:0] CAP_V = FILL_W'(HOLD_CAP);

  logic [MIN_W-1:0]   min_count_r;
  logic [KEY_W-1:0]   run_key_r, run_key_nxt;
  logic [COUNT_W-1:0] run_count_r, run_count_nxt;
  logic               run_open_r, run_open_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;

  logic               accept;
  logic               same_run;
  logic               run_passed;
  logic [COUNT_W-1:0] cnt_new;
  logic [FILL_W-1:0]  fill_base;
  logic               pass;
  cmd_t               cmd;

  assign in_stall   = q_full;
  assign accept     = in_valid && !q_full;
  assign same_run   = run_open_r && (in_user_key == run_key_r);
  assign run_passed = run_open_r && (run_count_r > {1'b0, min_count_r});

  // count and fill as they stand after this record
  assign cnt_new   = same_run ? ((run_count_r == COUNT_MAX) ? COUNT_MAX : run_count_r + 1'b1)
                              : COUNT_W'(1);
  assign fill_base = same_run ? fill_r : '0;
  assign pass      = cnt_new > {1'b0, min_count_r};

  // classify the word
  always_comb begin
    cmd           = '0;
    cmd.end_key   = run_key_r;
    cmd.key       = in_user_key;
    cmd.payload   = in_payload;
    run_key_nxt   = run_key_r;
    run_count_nxt = run_count_r;
    run_open_nxt  = run_open_r;
    fill_nxt      = fill_r;
    if (in_action == ACT_EOS) begin
      cmd.end_flag  = run_passed;
      run_open_nxt  = 1'b0;
      run_count_nxt = '0;
      fill_nxt      = '0;
    end else begin
      cmd.end_flag  = run_passed && !same_run;
      run_key_nxt   = in_user_key;
      run_count_nxt = cnt_new;
      run_open_nxt  = 1'b1;
      if (pass) begin
        cmd.rec   = 1'b1;
        cmd.rel_n = fill_base;
        fill_nxt  = '0;
      end else if (fill_base < CAP_V) begin
        cmd.hold = 1'b1;
        cmd.idx  = fill_base;
        fill_nxt = fill_base + 1'b1;
      end else begin
        fill_nxt = fill_base;
      end
    end
  end

  assign q_data = cmd;
  assign q_push = accept && (cmd.end_flag || cmd.rec || cmd.hold);

  // run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_key_r   <= '0;
      run_count_r <= '0;
      run_open_r  <= 1'b0;
      fill_r      <= '0;
    end else if (accept) begin
      run_key_r   <= run_key_nxt;
      run_count_r <= run_count_nxt;
      run_open_r  <= run_open_nxt;
      fill_r      <= fill_nxt;
    end
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_count_r <= MIN_COUNT_RST;
    end else if (cfg_we) begin
      min_count_r <= cfg_wdata;
    end
  end

endmodule

### design/gmcf_back.sv
// ----------------------------------------------------------------------------
// gmcf_back
// Executes queued commands: keeps the hold buffer, sends end markers,
// replays held records and passes records through an output register.
// ----------------------------------------------------------------------------
module gmcf_back
  import gmcf_pkg::*;
#(
  parameter int HOLD_DEPTH = 64
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             q_data,
  input  logic             q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [KEY_W-1:0] out_key,
  output logic [PAY_W-1:0] out_payload,
  output logic             out_last
);

  localparam int HOLD_CAP = (HOLD_DEPTH < HOLD_LIMIT) ? HOLD_DEPTH : HOLD_LIMIT;
  localparam int IDX_W    = (HOLD_CAP > 1) ? $clog2(HOLD_CAP) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_END  = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_HELD = 3'd3;
  localparam logic [2:0] S_REC  = 3'd4;

  logic [PAY_W-1:0]  hold_mem [HOLD_CAP];
  logic [PAY_W-1:0]  rd_data_r;

  logic [2:0]        state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_last_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [PAY_W-1:0]  out_payload_r;

  logic              can_load, load;
  logic              ld_kind, ld_last;
  logic [KEY_W-1:0]  ld_key;
  logic [PAY_W-1:0]  ld_payload;
  logic              hold_we;

  assign can_load = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    hold_we    = 1'b0;
    load       = 1'b0;
    ld_kind    = KIND_RECORD;
    ld_last    = 1'b0;
    ld_key     = cmd_r.key;
    ld_payload = cmd_r.payload;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          hold_we = q_data.hold;
          cmd_nxt = q_data;
          idx_nxt = '0;
          if (q_data.end_flag) begin
            state_nxt = S_END;
          end else if (q_data.rel_n != '0) begin
            state_nxt = S_READ;
          end else if (q_data.rec) begin
            state_nxt = S_REC;
          end
        end
      end
      S_END: begin
        if (can_load) begin
          load       = 1'b1;
          ld_kind    = KIND_RUN_END;
          ld_key     = cmd_r.end_key;
          ld_payload = '0;
          ld_last    = !cmd_r.rec && (cmd_r.rel_n == '0);
          if (cmd_r.rel_n != '0) begin
            state_nxt = S_READ;
          end else if (cmd_r.rec) begin
            state_nxt = S_REC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_READ: begin
        // read data lands in rd_data_r
        state_nxt = S_HELD;
      end
      S_HELD: begin
        if (can_load) begin
          load       = 1'b1;
          ld_payload = rd_data_r;
          idx_nxt    = idx_r + 1'b1;
          state_nxt  = (idx_r + 1'b1 == cmd_r.rel_n) ? S_REC : S_READ;
        end
      end
      S_REC: begin
        if (can_load) begin
          load      = 1'b1;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // command and output payload
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (load) begin
      out_kind_r    <= ld_kind;
      out_key_r     <= ld_key;
      out_payload_r <= ld_payload;
      out_last_r    <= ld_last;
    end
  end

  // hold buffer write
  always_ff @(posedge clk) begin
    if (hold_we) begin
      hold_mem[q_data.idx[IDX_W-1:0]] <= q_data.payload;
    end
  end

  // hold buffer registered read
  always_ff @(posedge clk) begin
    rd_data_r <= hold_mem[idx_r[IDX_W-1:0]];
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_key     = out_key_r;
  assign out_payload = out_payload_r;
  assign out_last    = out_last_r;

endmodule

### design/group_min_count_filter.sv
// ----------------------------------------------------------------------------
// group_min_count_filter
// Passes runs of equal user keys that hold more records than min_count.
// ----------------------------------------------------------------------------
// A record that changes nothing but the run state is absorbed by the front
// end; other words queue a command (four deep) for the back end, whose
// sequencer picks it up in S_IDLE and sends its results, replaying each held
// record at the threshold through S_READ and S_HELD because each hold buffer
// read is registered. The back end's sequencer and its single hold buffer
// read port set the pace of the output. A full queue stalls the input.
// min_count is written through cfg_we/cfg_wdata and must only change while
// the block is idle.
module group_min_count_filter
  import gmcf_pkg::*;
#(
  parameter int HOLD_DEPTH = 64
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_action,
  input  logic [KEY_W-1:0] in_user_key,
  input  logic [PAY_W-1:0] in_payload,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_kind,
  output logic [KEY_W-1:0] out_key,
  output logic [PAY_W-1:0] out_payload,
  output logic             out_last,
  input  logic             cfg_we,
  input  logic [MIN_W-1:0] cfg_wdata
);

  logic q_push, q_pop, q_full, q_empty;
  cmd_t q_wdata, q_rdata;

  // classify words and track runs
  gmcf_front #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_user_key (in_user_key),
    .in_payload  (in_payload),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_push      (q_push),
    .q_data      (q_wdata),
    .q_full      (q_full)
  );

  // command queue
  gmcf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  // hold buffer and output sequencing
  gmcf_back #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_data      (q_rdata),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_key     (out_key),
    .out_payload (out_payload),
    .out_last    (out_last)
  );

endmodule

### test/tb_group_min_count_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_group_min_count_filter
// Drives record and end-of-stream words into the group minimum-count filter
// under random sender and receiver idling. A model of the run state and the
// hold buffer predicts every result word, which is checked field by field.
// ----------------------------------------------------------------------------
module tb_group_min_count_filter;
  import gmcf_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 24;

  typedef struct {
    logic             kind;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic             last;
  } result_word_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             in_action;
  logic [KEY_W-1:0] in_user_key;
  logic [PAY_W-1:0] in_payload;
  logic             out_valid;
  logic             out_stall;
  logic             out_kind;
  logic [KEY_W-1:0] out_key;
  logic [PAY_W-1:0] out_payload;
  logic             out_last;
  logic             cfg_we;
  logic [MIN_W-1:0] cfg_wdata;

  // filter model state
  logic [MIN_W-1:0]   mdl_min;
  logic [KEY_W-1:0]   mdl_key;
  logic [COUNT_W-1:0] mdl_count;
  logic               mdl_open;
  logic [PAY_W-1:0]   mdl_held[$];

  result_word_t pending_words[$];

  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int words_sent;
  int words_checked;
  int markers_seen;
  int cycle_count;

  group_min_count_filter uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_user_key (in_user_key),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_key     (out_key),
    .out_payload (out_payload),
    .out_last    (out_last),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, pending_words.size());
      $display("tb_group_min_count_filter: FAIL");
      $finish;
    end
  end

  // receiver stall, changed at the falling edge
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // work out the result words of one accepted input word
  task automatic predict_filter(input logic act, input logic [KEY_W-1:0] key,
                                input logic [PAY_W-1:0] pay);
    result_word_t words[$];
    result_word_t w;
    w.last = 1'b0;
    if (act == ACT_EOS) begin
      if (mdl_open && mdl_count > mdl_min) begin
        w.kind = KIND_RUN_END; w.key = mdl_key; w.payload = '0;
        words.push_back(w);
      end
      mdl_open  = 1'b0;
      mdl_count = '0;
      mdl_held.delete();
    end else begin
      if (mdl_open && key == mdl_key) begin
        if (mdl_count < COUNT_MAX) mdl_count++;
      end else begin
        if (mdl_open && mdl_count > mdl_min) begin
          w.kind = KIND_RUN_END; w.key = mdl_key; w.payload = '0;
          words.push_back(w);
        end
        mdl_key   = key;
        mdl_count = COUNT_W'(1);
        mdl_open  = 1'b1;
        mdl_held.delete();
      end
      // past the threshold: replay held records, then this one
      if (mdl_count > mdl_min) begin
        w.kind = KIND_RECORD; w.key = mdl_key;
        foreach (mdl_held[i]) begin
          w.payload = mdl_held[i];
          words.push_back(w);
        end
        mdl_held.delete();
        w.payload = pay;
        words.push_back(w);
      end else if (mdl_held.size() < HOLD_LIMIT) begin
        mdl_held.push_back(pay);
      end
    end
    foreach (words[i]) begin
      w = words[i];
      w.last = (i == words.size() - 1);
      pending_words.push_back(w);
    end
  endtask

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    result_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      words_checked++;
      if (out_kind == KIND_RUN_END) markers_seen++;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: kind=%0d key=%h pay=%h last=%0d",
                   out_kind, out_key, out_payload, out_last);
      end else begin
        exp_w = pending_words.pop_front();
        if (out_kind !== exp_w.kind || out_key !== exp_w.key ||
            out_payload !== exp_w.payload || out_last !== exp_w.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at cycle %0d: expected kind=%0d key=%h pay=%h last=%0d",
                     cycle_count, exp_w.kind, exp_w.key, exp_w.payload, exp_w.last);
            $display("  got kind=%0d key=%h pay=%h last=%0d",
                     out_kind, out_key, out_payload, out_last);
          end
        end
      end
    end
  end

  // send one input word, with random idle cycles ahead of it
  task automatic send_word(input logic act, input logic [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] pay);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_action   = act;
    in_user_key = key;
    in_payload  = pay;
    do @(posedge clk); while (in_stall);
    predict_filter(act, key, pay);
    words_sent++;
  endtask

  task automatic send_record(input logic [KEY_W-1:0] key);
    send_word(ACT_RECORD, key, {$urandom, $urandom});
  endtask

  task automatic send_eos();
    send_word(ACT_EOS, {$urandom}, {$urandom, $urandom});
  endtask

  // stop sending and wait until every expected word has come out
  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // min_count is only written with the block drained
  task automatic write_min_count(input logic [MIN_W-1:0] value);
    wait_drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    mdl_min = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // reset threshold of 50: short runs vanish, end of stream with no run
  task automatic test_default_threshold();
    send_eos();
    send_record(32'd5);
    send_record(32'd5);
    send_record(32'd5);
    send_eos();
  endtask

  // threshold 0: every record passes, markers on key change and end of stream
  task automatic test_pass_through();
    write_min_count(6'd0);
    send_word(ACT_RECORD, 32'h0000_0000, 64'h0);
    send_word(ACT_RECORD, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(ACT_RECORD, 32'hFFFF_FFFF, 64'h5555_5555_AAAA_AAAA);
    send_word(ACT_EOS, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_eos();
    // same key after end of stream opens a new run, no marker
    send_word(ACT_RECORD, 32'hFFFF_FFFF, 64'hAAAA_AAAA_5555_5555);
    send_eos();
  endtask

  // threshold 2: release of held records, short run dropped
  task automatic test_release();
    write_min_count(6'd2);
    repeat (3) send_record(32'hA5A5_0001);
    repeat (2) send_record(32'h5A5A_0002);
    send_eos();
    repeat (4) send_record(32'h0000_00C3);
    send_eos();
  endtask

  // threshold written while a run is open
  task automatic test_threshold_change();
    write_min_count(6'd5);
    repeat (3) send_record(32'h1234_5678);
    write_min_count(6'd1);
    send_record(32'h1234_5678);
    write_min_count(6'd10);
    send_record(32'h1234_5678);
    send_record(32'h8765_4321);
    send_eos();
  endtask

  // threshold 63: full hold buffer release and counter saturation
  task automatic test_long_runs();
    write_min_count(6'd63);
    repeat (130) send_record(32'hCAFE_0001);
    repeat (3) send_record(32'hCAFE_0002);
    send_eos();
  endtask

  // random runs around the threshold, with noise and stray end of stream
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_words);
    int sent;
    int r;
    int k;
    int len;
    logic [KEY_W-1:0] key;
    wait_drain();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    for (int phase = 0; phase < 2; phase++) begin
      write_min_count($urandom_range(0, 8));
      while (sent < (phase + 1) * n_words / 2) begin
        r = $urandom_range(99);
        if (r < 8) begin
          send_eos();
          sent++;
        end else begin
          k = $urandom_range(9);
          if (k < 6) key = $urandom;
          else if (k < 8) key = $urandom_range(3);
          else if (k == 8) key = '0;
          else key = '1;
          if (r < 88) len = $urandom_range(1, mdl_min + 3);
          else len = $urandom_range(1, 2);
          repeat (len) send_record(key);
          sent += len;
        end
      end
    end
  endtask

  // main sequence
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_RECORD;
    in_user_key    = '0;
    in_payload     = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    send_idle_pct  = 14;
    recv_stall_pct = 81;
    mismatches     = 0;
    words_sent     = 0;
    words_checked  = 0;
    markers_seen   = 0;
    mdl_min        = MIN_COUNT_RST;
    mdl_key        = '0;
    mdl_count      = '0;
    mdl_open       = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_default_threshold();
    test_pass_through();
    test_release();
    test_threshold_change();
    test_long_runs();
    test_random_traffic(14, 81, 16);
    test_random_traffic(81, 14, 16);
    test_random_traffic(0, 0, 16);

    wait_drain();
    repeat (SETTLE) @(posedge clk);
    $display("sent %0d input words and checked %0d result words (%0d run end markers)",
             words_sent, words_checked, markers_seen);
    $display("thresholds from 0 to 63, changes inside a run, full hold release, saturation");
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("tb_group_min_count_filter: PASS");
    end else begin
      $display("%0d mismatches, %0d words never arrived", mismatches, pending_words.size());
      $display("tb_group_min_count_filter: FAIL");
    end
    $finish;
  end

endmodule
